@@ hdl/poci_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package poci_pkg;

  localparam int RANK_W           = 6;
  localparam int EXT_W            = RANK_W + 1;
  localparam int CNT_W            = 6;
  localparam int POP_W            = 64;
  localparam int MAX_ELEMENTS_DEF = 32;
  localparam logic [RANK_W-1:0] ELEM_COUNT_RST = 6'd32;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_COUNT = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_ADD_RA,
    ST_ADD_RB,
    ST_ADD_WB,
    ST_ADD_DEC,
    ST_SCAN,
    ST_CHECK,
    ST_WRITE,
    ST_CNT_RD,
    ST_CNT_WAIT,
    ST_DONE
  } state_e;

  // What the row unit does with the data of the read issued in the cycle before
  typedef enum logic [2:0] {
    TAG_NONE,
    TAG_A,
    TAG_B,
    TAG_SCAN,
    TAG_WRITE,
    TAG_COUNT
  } tag_e;

  typedef struct packed {
    logic rd_en;
    tag_e rd_tag;
    logic init_scan;
    logic set_conflict;
    logic clear_all;
    logic clear_count;
    logic done;
  } ctl_t;

  typedef struct packed {
    logic present;
    logic cyc;
    logic overlap;
    logic conflict;
  } sts_t;

  // Population count as a tree of six masked adds
  function automatic logic [6:0] popcount64(input logic [POP_W-1:0] v);
    logic [POP_W-1:0] x;
    x = v;
    x = (x & 64'h5555_5555_5555_5555) + ((x >> 1)  & 64'h5555_5555_5555_5555);
    x = (x & 64'h3333_3333_3333_3333) + ((x >> 2)  & 64'h3333_3333_3333_3333);
    x = (x & 64'h0f0f_0f0f_0f0f_0f0f) + ((x >> 4)  & 64'h0f0f_0f0f_0f0f_0f0f);
    x = (x & 64'h00ff_00ff_00ff_00ff) + ((x >> 8)  & 64'h00ff_00ff_00ff_00ff);
    x = (x & 64'h0000_ffff_0000_ffff) + ((x >> 16) & 64'h0000_ffff_0000_ffff);
    x = (x & 64'h0000_0000_ffff_ffff) + ((x >> 32) & 64'h0000_0000_ffff_ffff);
    return x[6:0];
  endfunction

endpackage

`default_nettype wire

@@ hdl/poci_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module poci_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ hdl/poci_row_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

module poci_row_unit #(
  parameter int MAX_ELEMENTS = poci_pkg::MAX_ELEMENTS_DEF,
  parameter int AW = $clog2(MAX_ELEMENTS),
  parameter int NW = $clog2(MAX_ELEMENTS + 1)
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire poci_pkg::ctl_t            ctl_i,
  input  wire logic [AW-1:0]             rd_addr_i,
  input  wire logic [AW-1:0]             a_idx_i,
  input  wire logic [AW-1:0]             b_idx_i,
  input  wire logic [NW-1:0]             n_i,
  input  wire logic [MAX_ELEMENTS-1:0]   ram_rdata_i,
  output logic                           ram_we_o,
  output logic      [AW-1:0]             ram_waddr_o,
  output logic      [MAX_ELEMENTS-1:0]   ram_wdata_o,
  output poci_pkg::sts_t                 sts_o,
  output logic      [poci_pkg::CNT_W-1:0] count_o
);

  localparam int M = MAX_ELEMENTS;

  logic [M-1:0]        valid_q;
  logic [AW-1:0]       row_idx_q;
  poci_pkg::tag_e      tag_q;
  logic [M-1:0]        up_q, down_q, dacc_q;
  logic                present_q, cyc_q, conflict_q;
  logic [poci_pkg::CNT_W-1:0] count_q;

  logic [M-1:0] mask, abit, bbit, row;
  logic [6:0]   pop;

  always_comb begin
    for (int i = 0; i < M; i++) begin
      mask[i] = (NW'(i) < n_i);
    end
  end

  assign abit = {{(M-1){1'b0}}, 1'b1} << a_idx_i;
  assign bbit = {{(M-1){1'b0}}, 1'b1} << b_idx_i;
  // a row never written since the last clear reads as empty
  assign row  = valid_q[row_idx_q] ? ram_rdata_i : '0;
  assign pop  = poci_pkg::popcount64(poci_pkg::POP_W'(row & mask));

  assign ram_we_o    = (tag_q == poci_pkg::TAG_WRITE) && up_q[row_idx_q];
  assign ram_waddr_o = row_idx_q;
  assign ram_wdata_o = row | down_q;

  assign sts_o.present  = present_q;
  assign sts_o.cyc      = cyc_q;
  assign sts_o.overlap  = |(dacc_q & up_q);
  assign sts_o.conflict = conflict_q;
  assign count_o        = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      tag_q      <= poci_pkg::TAG_NONE;
      conflict_q <= 1'b0;
      count_q    <= '0;
      present_q  <= 1'b0;
      cyc_q      <= 1'b0;
    end else begin
      tag_q <= ctl_i.rd_en ? ctl_i.rd_tag : poci_pkg::TAG_NONE;
      if (ctl_i.clear_all) begin
        valid_q    <= '0;
        conflict_q <= 1'b0;
      end else begin
        if (ram_we_o) begin
          valid_q[row_idx_q] <= 1'b1;
        end
        if (ctl_i.set_conflict) begin
          conflict_q <= 1'b1;
        end
      end
      if (ctl_i.clear_count) begin
        count_q <= '0;
      end else if (tag_q == poci_pkg::TAG_COUNT) begin
        count_q <= pop[poci_pkg::CNT_W-1:0];
      end
      if (tag_q == poci_pkg::TAG_A) begin
        present_q <= row[b_idx_i];
      end
      if (tag_q == poci_pkg::TAG_B) begin
        cyc_q <= row[a_idx_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    row_idx_q <= rd_addr_i;
    if (tag_q == poci_pkg::TAG_B) begin
      down_q <= (bbit | row) & mask;
    end
    if (ctl_i.init_scan) begin
      up_q   <= abit;
      dacc_q <= '0;
    end else if (tag_q == poci_pkg::TAG_SCAN) begin
      if ((row & abit) != '0) begin
        up_q[row_idx_q] <= 1'b1;
      end
      if (down_q[row_idx_q]) begin
        dacc_q <= dacc_q | (row & mask);
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/poci_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none

module poci_seq #(
  parameter int MAX_ELEMENTS = poci_pkg::MAX_ELEMENTS_DEF,
  parameter int AW = $clog2(MAX_ELEMENTS),
  parameter int NW = $clog2(MAX_ELEMENTS + 1)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [1:0]                  opcode_i,
  input  wire logic [poci_pkg::RANK_W-1:0] first_rank_i,
  input  wire logic [poci_pkg::RANK_W-1:0] second_rank_i,
  input  wire logic [NW-1:0]               n_i,
  input  wire poci_pkg::sts_t              sts_i,
  output logic                             busy_o,
  output poci_pkg::ctl_t                   ctl_o,
  output logic      [AW-1:0]               rd_addr_o,
  output logic      [AW-1:0]               a_idx_o,
  output logic      [AW-1:0]               b_idx_o
);

  poci_pkg::state_e state_q, state_d;
  logic [poci_pkg::RANK_W-1:0] a_q, a_d, b_q, b_d;
  logic [NW-1:0] ptr_q, ptr_d;
  logic [poci_pkg::RANK_W-1:0] a_m1, b_m1;
  logic [poci_pkg::EXT_W-1:0]  n_ext;
  logic a_ok, b_ok, accept;
  poci_pkg::op_e op_in;

  assign op_in  = poci_pkg::op_e'(opcode_i);
  assign accept = start_i && (state_q == poci_pkg::ST_IDLE);
  assign n_ext  = poci_pkg::EXT_W'(n_i);
  assign a_ok   = (first_rank_i != '0)
               && (poci_pkg::EXT_W'(first_rank_i) <= n_ext);
  assign b_ok   = (second_rank_i != '0)
               && (poci_pkg::EXT_W'(second_rank_i) <= n_ext);
  assign a_m1    = a_q - 6'd1;
  assign b_m1    = b_q - 6'd1;
  assign a_idx_o = a_m1[AW-1:0];
  assign b_idx_o = b_m1[AW-1:0];
  assign busy_o  = (state_q != poci_pkg::ST_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    a_d     = a_q;
    b_d     = b_q;
    ptr_d   = ptr_q;
    unique case (state_q)
      poci_pkg::ST_IDLE: begin
        if (accept) begin
          a_d = first_rank_i;
          b_d = second_rank_i;
          unique case (op_in)
            poci_pkg::OP_CLEAR: state_d = poci_pkg::ST_CLEAR;
            poci_pkg::OP_ADD: begin
              if (sts_i.conflict || !a_ok || !b_ok) begin
                state_d = poci_pkg::ST_DONE;
              end else begin
                state_d = poci_pkg::ST_ADD_RA;
              end
            end
            poci_pkg::OP_COUNT: begin
              state_d = a_ok ? poci_pkg::ST_CNT_RD : poci_pkg::ST_DONE;
            end
            poci_pkg::OP_NOP: state_d = poci_pkg::ST_DONE;
          endcase
        end
      end
      poci_pkg::ST_CLEAR:  state_d = poci_pkg::ST_DONE;
      poci_pkg::ST_ADD_RA: state_d = poci_pkg::ST_ADD_RB;
      poci_pkg::ST_ADD_RB: state_d = poci_pkg::ST_ADD_WB;
      poci_pkg::ST_ADD_WB: state_d = poci_pkg::ST_ADD_DEC;
      poci_pkg::ST_ADD_DEC: begin
        ptr_d = '0;
        priority if (sts_i.present) begin
          state_d = poci_pkg::ST_DONE;
        end else if ((a_q == b_q) || sts_i.cyc) begin
          state_d = poci_pkg::ST_DONE;
        end else begin
          state_d = poci_pkg::ST_SCAN;
        end
      end
      poci_pkg::ST_SCAN: begin
        ptr_d = ptr_q + 1'b1;
        if (ptr_q == n_i) begin
          state_d = poci_pkg::ST_CHECK;
        end
      end
      poci_pkg::ST_CHECK: begin
        ptr_d   = '0;
        state_d = sts_i.overlap ? poci_pkg::ST_DONE : poci_pkg::ST_WRITE;
      end
      poci_pkg::ST_WRITE: begin
        ptr_d = ptr_q + 1'b1;
        if (ptr_q == n_i) begin
          state_d = poci_pkg::ST_DONE;
        end
      end
      poci_pkg::ST_CNT_RD:   state_d = poci_pkg::ST_CNT_WAIT;
      poci_pkg::ST_CNT_WAIT: state_d = poci_pkg::ST_DONE;
      poci_pkg::ST_DONE:     state_d = poci_pkg::ST_IDLE;
      default:               state_d = poci_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl_o     = '0;
    ctl_o.rd_tag = poci_pkg::TAG_NONE;
    rd_addr_o = ptr_q[AW-1:0];
    unique case (state_q)
      poci_pkg::ST_IDLE: begin
        ctl_o.clear_count  = accept;
        ctl_o.set_conflict = accept && (op_in == poci_pkg::OP_ADD)
                          && !sts_i.conflict && (!a_ok || !b_ok);
      end
      poci_pkg::ST_CLEAR: ctl_o.clear_all = 1'b1;
      poci_pkg::ST_ADD_RA: begin
        ctl_o.rd_en  = 1'b1;
        ctl_o.rd_tag = poci_pkg::TAG_A;
        rd_addr_o    = a_idx_o;
      end
      poci_pkg::ST_ADD_RB: begin
        ctl_o.rd_en  = 1'b1;
        ctl_o.rd_tag = poci_pkg::TAG_B;
        rd_addr_o    = b_idx_o;
      end
      poci_pkg::ST_ADD_WB: ctl_o.rd_en = 1'b0;
      poci_pkg::ST_ADD_DEC: begin
        ctl_o.init_scan    = 1'b1;
        ctl_o.set_conflict = !sts_i.present && ((a_q == b_q) || sts_i.cyc);
      end
      poci_pkg::ST_SCAN: begin
        ctl_o.rd_en  = (ptr_q < n_i);
        ctl_o.rd_tag = poci_pkg::TAG_SCAN;
      end
      poci_pkg::ST_CHECK: ctl_o.set_conflict = sts_i.overlap;
      poci_pkg::ST_WRITE: begin
        ctl_o.rd_en  = (ptr_q < n_i);
        ctl_o.rd_tag = poci_pkg::TAG_WRITE;
      end
      poci_pkg::ST_CNT_RD: begin
        ctl_o.rd_en  = 1'b1;
        ctl_o.rd_tag = poci_pkg::TAG_COUNT;
        rd_addr_o    = a_idx_o;
      end
      poci_pkg::ST_CNT_WAIT: ctl_o.rd_en = 1'b0;
      poci_pkg::ST_DONE:     ctl_o.done = 1'b1;
      default:               ctl_o.rd_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= poci_pkg::ST_IDLE;
      ptr_q   <= '0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
  end

endmodule

`default_nettype wire

@@ hdl/partial_order_closure_insert.sv @@
// Incremental transitive closure of a strict partial order over ranks 1..n.
// Request channel: opcode_i, first_rank_i, second_rank_i are taken at a rising
// edge with start high and busy low. busy stays high until the result has been
// shown; one request is in flight at a time.
// Result channel: done_o is high for exactly one cycle with consistent_o and
// successor_count_o; the receiver cannot stall it, so take it in that cycle.
// Configuration: element_count_we_i writes element_count_i at any edge; write
// only while busy is low. The count in use is min(element_count, MAX_ELEMENTS).
// busy drops in the cycle after done_o. A full add has the shared row unit
// walk the matrix RAM one row per cycle through its single read port: one
// pass gathers the rows above a and the successors of the rows below b, a
// compare decides, a second pass ORs the new successors in. The insert is
// atomic: a conflict sets the sticky flag and writes nothing.
// Reset: matrix reads as empty (per-row valid bits), flag clear, element
// count 32; the block is ready in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module partial_order_closure_insert #(
  parameter int MAX_ELEMENTS = poci_pkg::MAX_ELEMENTS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [1:0]                  opcode_i,
  input  wire logic [poci_pkg::RANK_W-1:0] first_rank_i,
  input  wire logic [poci_pkg::RANK_W-1:0] second_rank_i,
  input  wire logic                        element_count_we_i,
  input  wire logic [poci_pkg::RANK_W-1:0] element_count_i,
  output logic                             done_o,
  output logic                             consistent_o,
  output logic      [poci_pkg::CNT_W-1:0]  successor_count_o
);

  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int NW = $clog2(MAX_ELEMENTS + 1);

  logic [poci_pkg::RANK_W-1:0] elem_count_q;
  logic [NW-1:0]               n_in_use;

  poci_pkg::ctl_t ctl;
  poci_pkg::sts_t sts;

  logic [AW-1:0]           rd_addr, a_idx, b_idx, waddr;
  logic                    we;
  logic [MAX_ELEMENTS-1:0] wdata, rdata;

  // hold the element count; the user must change it only between requests, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_count_q <= poci_pkg::ELEM_COUNT_RST;
    end else if (element_count_we_i) begin
      elem_count_q <= element_count_i;
    end
  end

  // clamp to the rows that exist
  always_comb begin
    if (poci_pkg::EXT_W'(elem_count_q) > poci_pkg::EXT_W'(MAX_ELEMENTS)) begin
      n_in_use = NW'(MAX_ELEMENTS);
    end else begin
      n_in_use = NW'(elem_count_q);
    end
  end

  poci_seq #(
    .MAX_ELEMENTS(MAX_ELEMENTS),
    .AW(AW),
    .NW(NW)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .opcode_i     (opcode_i),
    .first_rank_i (first_rank_i),
    .second_rank_i(second_rank_i),
    .n_i          (n_in_use),
    .sts_i        (sts),
    .busy_o       (busy),
    .ctl_o        (ctl),
    .rd_addr_o    (rd_addr),
    .a_idx_o      (a_idx),
    .b_idx_o      (b_idx)
  );

  poci_ram #(
    .WIDTH(MAX_ELEMENTS),
    .DEPTH(MAX_ELEMENTS)
  ) u_matrix (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (ctl.rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rdata)
  );

  poci_row_unit #(
    .MAX_ELEMENTS(MAX_ELEMENTS),
    .AW(AW),
    .NW(NW)
  ) u_row (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .rd_addr_i  (rd_addr),
    .a_idx_i    (a_idx),
    .b_idx_i    (b_idx),
    .n_i        (n_in_use),
    .ram_rdata_i(rdata),
    .ram_we_o   (we),
    .ram_waddr_o(waddr),
    .ram_wdata_o(wdata),
    .sts_o      (sts),
    .count_o    (successor_count_o)
  );

  // drive the result for its single cycle
  assign done_o       = ctl.done;
  assign consistent_o = !sts.conflict;

endmodule

`default_nettype wire

@@ verif/closure_checker.sv @@
`timescale 1ns / 1ps

module closure_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  input  logic                        busy,
  input  logic [1:0]                  opcode_i,
  input  logic [poci_pkg::RANK_W-1:0] first_rank_i,
  input  logic [poci_pkg::RANK_W-1:0] second_rank_i,
  input  logic                        element_count_we_i,
  input  logic [poci_pkg::RANK_W-1:0] element_count_i,
  input  logic                        done_o,
  input  logic                        consistent_o,
  input  logic [poci_pkg::CNT_W-1:0]  successor_count_o,
  output int                          mismatches,
  output int unsigned                 outstanding
);

  import poci_pkg::*;

  localparam int ROWS = MAX_ELEMENTS_DEF;

  typedef logic [ROWS-1:0] row_t;

  typedef struct packed {
    logic             consistent;
    logic [CNT_W-1:0] successors;
  } outcome_t;

  row_t             closure_rows [ROWS];
  logic             conflict_flag;
  logic [RANK_W-1:0] elem_cfg;
  outcome_t         awaited_outcomes [$];

  function automatic int unsigned live_count();
    if (elem_cfg > ROWS) return ROWS;
    return elem_cfg;
  endfunction

  function automatic row_t live_mask(int unsigned n);
    if (n >= ROWS) return '1;
    return (row_t'(1) << n) - row_t'(1);
  endfunction

  // Insert a before b with transitive closure; all or nothing
  function automatic bit close_pair(int unsigned a, int unsigned b, int unsigned n);
    row_t mask;
    row_t abit;
    row_t above;
    row_t below;
    mask = live_mask(n);
    if (a == 0 || b == 0 || a > n || b > n) return 1'b0;
    abit = row_t'(1) << (a - 1);
    if (closure_rows[a-1][b-1]) return 1'b1;
    if (a == b || closure_rows[b-1][a-1]) return 1'b0;
    above = abit;
    for (int i = 0; i < n; i++) begin
      if (|(closure_rows[i] & abit)) above[i] = 1'b1;
    end
    above &= mask;
    below = ((row_t'(1) << (b - 1)) | closure_rows[b-1]) & mask;
    for (int i = 0; i < n; i++) begin
      if (below[i] && |(closure_rows[i] & above)) return 1'b0;
    end
    for (int i = 0; i < n; i++) begin
      if (above[i]) closure_rows[i] |= below;
    end
    return 1'b1;
  endfunction

  function automatic outcome_t apply_request(logic [1:0] op, logic [RANK_W-1:0] a,
                                             logic [RANK_W-1:0] b);
    int unsigned n;
    int unsigned succ;
    outcome_t    res;
    n = live_count();
    succ = 0;
    case (op_e'(op))
      OP_CLEAR: begin
        for (int i = 0; i < ROWS; i++) closure_rows[i] = '0;
        conflict_flag = 1'b0;
      end
      OP_ADD: begin
        if (!conflict_flag && !close_pair(a, b, n)) conflict_flag = 1'b1;
      end
      OP_COUNT: begin
        if (a != 0 && a <= n) succ = $countones(closure_rows[a-1] & live_mask(n));
      end
      default: begin
      end
    endcase
    res.consistent = ~conflict_flag;
    res.successors = succ[CNT_W-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t got;
    outcome_t want;
    if (!rst_ni) begin
      for (int i = 0; i < ROWS; i++) closure_rows[i] = '0;
      conflict_flag = 1'b0;
      elem_cfg = ELEM_COUNT_RST;
      awaited_outcomes.delete();
      mismatches = 0;
      outstanding <= 0;
    end else begin
      if (element_count_we_i) elem_cfg = element_count_i;
      if (done_o) begin
        got.consistent = consistent_o;
        got.successors = successor_count_o;
        if (awaited_outcomes.size() == 0) begin
          $error("result with no request waiting: consistent %0d, successor_count %0d",
                 got.consistent, got.successors);
          mismatches++;
        end else begin
          want = awaited_outcomes.pop_front();
          if (got.consistent !== want.consistent) begin
            $error("consistent: expected %0d, got %0d", want.consistent, got.consistent);
            mismatches++;
          end
          if (got.successors !== want.successors) begin
            $error("successor_count: expected %0d, got %0d", want.successors,
                   got.successors);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        awaited_outcomes.push_back(apply_request(opcode_i, first_rank_i, second_rank_i));
      end
      outstanding <= awaited_outcomes.size();
    end
  end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  import poci_pkg::*;

  // Longest request is a full add at 32 elements
  localparam int DRAIN_CYCLES   = 2 * MAX_ELEMENTS_DEF + 16;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASE_ITEMS    = 170;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        opcode = OP_NOP;
  logic [RANK_W-1:0] first_rank = '0;
  logic [RANK_W-1:0] second_rank = '0;
  logic              count_we = 1'b0;
  logic [RANK_W-1:0] count_val = '0;
  logic              done;
  logic              consistent;
  logic [CNT_W-1:0]  successor_count;

  int                fail_count;
  int unsigned       outstanding;
  int                idle_cycles = 0;
  int unsigned       live_n = MAX_ELEMENTS_DEF;
  bit                calm = 1'b0;

  partial_order_closure_insert dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .opcode_i           (opcode),
    .first_rank_i       (first_rank),
    .second_rank_i      (second_rank),
    .element_count_we_i (count_we),
    .element_count_i    (count_val),
    .done_o             (done),
    .consistent_o       (consistent),
    .successor_count_o  (successor_count)
  );

  closure_checker u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .opcode_i           (opcode),
    .first_rank_i       (first_rank),
    .second_rank_i      (second_rank),
    .element_count_we_i (count_we),
    .element_count_i    (count_val),
    .done_o             (done),
    .consistent_o       (consistent),
    .successor_count_o  (successor_count),
    .mismatches         (fail_count),
    .outstanding        (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Count cycles with neither a request nor a result moving; give up when stuck
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic logic [RANK_W-1:0] any_rank();
    return RANK_W'($urandom_range(0, 63));
  endfunction

  // Rank inside the elements in use, or anything when none are in use
  function automatic logic [RANK_W-1:0] live_rank();
    if (live_n == 0) return any_rank();
    return RANK_W'($urandom_range(1, live_n));
  endfunction

  // Present one request and hold it until the block takes it. Keep start high
  // across back-to-back requests so it never drops and rises in one step.
  task automatic issue(op_e op, logic [RANK_W-1:0] a, logic [RANK_W-1:0] b);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start       <= 1'b1;
    opcode      <= op;
    first_rank  <= a;
    second_rank <= b;
    do @(posedge clk_i); while (busy);
  endtask

  // Drop start, wait for every result to come back, then let the block drain
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0 || busy);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_element_count(logic [RANK_W-1:0] value);
    settle();
    count_we  <= 1'b1;
    count_val <= value;
    @(posedge clk_i);
    count_we <= 1'b0;
    live_n = (value > MAX_ELEMENTS_DEF) ? MAX_ELEMENTS_DEF : value;
  endtask

  initial begin
    int plan [10];
    int perm [0:MAX_ELEMENTS_DEF];
    int phase_items;
    int len;
    int r;
    int i;
    int j;
    int tmp;

    plan = '{1, 2, 32, 5, 17, 0, 63, 31, 40, 12};
    plan[9] = $urandom_range(3, 30);

    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset element count of 32
    calm = 1'b1;
    issue(OP_COUNT, 6'd1, 6'd0);       // empty matrix
    issue(OP_ADD, 6'd1, 6'd2);
    issue(OP_ADD, 6'd2, 6'd3);
    issue(OP_ADD, 6'd3, 6'd32);        // chain closes through to the top rank
    issue(OP_COUNT, 6'd1, 6'd63);
    issue(OP_COUNT, 6'd32, 6'd0);
    issue(OP_ADD, 6'd1, 6'd3);         // pair already present
    issue(OP_COUNT, 6'd0, 6'd0);       // rank not in set
    issue(OP_COUNT, 6'd63, 6'd63);     // rank above n
    issue(OP_NOP, 6'd63, 6'd63);
    issue(OP_ADD, 6'd32, 6'd1);        // closes a cycle
    issue(OP_ADD, 6'd4, 6'd5);         // ignored while flagged
    issue(OP_COUNT, 6'd4, 6'd0);
    issue(OP_CLEAR, 6'd63, 6'd63);
    issue(OP_ADD, 6'd5, 6'd5);         // equal ranks
    issue(OP_CLEAR, 6'd0, 6'd0);
    issue(OP_ADD, 6'd0, 6'd1);         // zero rank
    issue(OP_CLEAR, 6'd0, 6'd0);
    issue(OP_ADD, 6'd1, 6'd63);        // rank above n
    issue(OP_CLEAR, 6'd0, 6'd0);
    issue(OP_ADD, 6'd2, 6'd1);
    issue(OP_ADD, 6'd31, 6'd32);
    issue(OP_COUNT, 6'd2, 6'd0);
    issue(OP_COUNT, 6'd31, 6'd0);

    // Random phases, each under its own element count
    foreach (plan[p]) begin
      set_element_count(RANK_W'(plan[p]));
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        // Mostly start from an empty order; sometimes keep what a wider count left
        if ($urandom_range(0, 3) != 0) begin
          issue(OP_CLEAR, any_rank(), any_rank());
          phase_items++;
        end
        calm = ($urandom_range(0, 3) == 0);
        for (i = 0; i <= MAX_ELEMENTS_DEF; i++) perm[i] = i;
        for (i = live_n; i > 1; i--) begin
          j = $urandom_range(1, i);
          tmp = perm[i];
          perm[i] = perm[j];
          perm[j] = tmp;
        end
        len = $urandom_range(4, 40);
        for (int k = 0; k < len; k++) begin
          r = $urandom_range(0, 99);
          if (r < 60 && live_n >= 2) begin
            // Forward pair under the shuffle: never a cycle, builds deep closure
            i = $urandom_range(1, live_n - 1);
            j = $urandom_range(i + 1, live_n);
            issue(OP_ADD, RANK_W'(perm[i]), RANK_W'(perm[j]));
            phase_items++;
          end else if (r < 85) begin
            issue(OP_COUNT, ($urandom_range(0, 9) == 0) ? any_rank() : live_rank(),
                  any_rank());
            phase_items++;
          end else if (r < 90) begin
            issue(OP_NOP, any_rank(), any_rank());
          end else if (r < 95 && live_n >= 2) begin
            // Backward pair: a cycle whenever the forward order already holds it
            i = $urandom_range(1, live_n - 1);
            j = $urandom_range(i + 1, live_n);
            issue(OP_ADD, RANK_W'(perm[j]), RANK_W'(perm[i]));
            phase_items++;
          end else begin
            issue(op_e'($urandom_range(0, 3)), any_rank(), any_rank());
            phase_items++;
          end
        end
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
